FILE: rtl/ecslm_pkg.sv
// Shared constants, types and sine table builder for the sine LFO modulator
`timescale 1ns / 1ps
`default_nettype none

package ecslm_pkg;

  // sizing
  localparam int unsigned SINE_TABLE_BITS = 10;
  localparam int unsigned FRAME_BITS      = 31;
  localparam int unsigned CHANNELS        = 8;
  localparam int unsigned LEVEL_W         = 16;
  localparam int unsigned FRAME_FIELD_W   = 31;
  localparam int unsigned S_TDATA_W       = 160;
  localparam int unsigned M_TDATA_W       = CHANNELS * LEVEL_W;

  // sine table
  localparam int unsigned SINE_N = 1 << SINE_TABLE_BITS;
  localparam int unsigned ROM_AW = SINE_TABLE_BITS + 1;

  // phase arithmetic widths
  localparam int unsigned PROD_W = FRAME_BITS + 16;  // frame * rate
  localparam int unsigned X_W    = PROD_W - 14;      // product above the low 14 bits
  localparam int unsigned QA_W   = X_W - 6;          // divisors are all above 64
  localparam int unsigned Y_W    = 25;               // remainder scaled into quotient
  localparam int unsigned RB_W   = 19;

  // pipeline
  localparam int unsigned STAGES      = 12;
  localparam int unsigned LANE_FIRST  = 2;
  localparam int unsigned LANE_STAGES = STAGES - LANE_FIRST;

  // configuration port
  localparam int unsigned CFG_AW = 2;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_AW-1:0] REG_AUTO_ENABLE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_MOD_DEPTH   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_LFO_RATE    = 2'd2;
  localparam logic [15:0]       LFO_RATE_RESET  = 16'd4096;

  // per channel: divisor 15 * period, so phase[31:16] = floor(4 * f * r / div)
  localparam int unsigned LANE_DIV [CHANNELS] = '{105, 165, 195, 255, 285, 345, 435, 465};
  localparam int unsigned LANE_OFFSET [CHANNELS] =
    '{0, 7301, 14603, 21904, 29205, 36506, 43808, 51109};
  localparam int unsigned LANE_HALF [CHANNELS] = '{0, 0, 0, 0, 1, 0, 1, 1};

  localparam longint unsigned RECIP_A [CHANNELS] = '{
    (64'd1 << X_W) / LANE_DIV[0], (64'd1 << X_W) / LANE_DIV[1],
    (64'd1 << X_W) / LANE_DIV[2], (64'd1 << X_W) / LANE_DIV[3],
    (64'd1 << X_W) / LANE_DIV[4], (64'd1 << X_W) / LANE_DIV[5],
    (64'd1 << X_W) / LANE_DIV[6], (64'd1 << X_W) / LANE_DIV[7]};
  localparam longint unsigned RECIP_B [CHANNELS] = '{
    (64'd1 << Y_W) / LANE_DIV[0], (64'd1 << Y_W) / LANE_DIV[1],
    (64'd1 << Y_W) / LANE_DIV[2], (64'd1 << Y_W) / LANE_DIV[3],
    (64'd1 << Y_W) / LANE_DIV[4], (64'd1 << Y_W) / LANE_DIV[5],
    (64'd1 << Y_W) / LANE_DIV[6], (64'd1 << Y_W) / LANE_DIV[7]};

  // fixed per-lane constants
  typedef struct packed {
    logic [8:0]       div;
    logic [QA_W-1:0]  recip_a;
    logic [RB_W-1:0]  recip_b;
    logic [15:0]      offset;
    logic             half;
  } lane_const_t;

  // modulation controls shared by all lanes
  typedef struct packed {
    logic        enable;
    logic        neg;
    logic [15:0] dmag;
  } mod_ctrl_t;

  typedef logic [15:0] sine_rom_t [SINE_N+1];

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam int unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};

  // quarter-wave table, Q2.30 Horner series to x^11, rounded to Q1.15
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sub;
    logic [63:0] s;
    logic [63:0] r;
    for (int j = 0; j <= int'(SINE_N); j++) begin
      x  = (64'(j) * HALF_PI_Q30) >> SINE_TABLE_BITS;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int i = 0; i < 5; i++) begin
        sub = ((x2 * t) >> 30) / 64'(HORNER_DIV[i]);
        t   = (sub >= Q30_ONE) ? 64'd0 : Q30_ONE - sub;
      end
      s = (x * t) >> 30;
      r = (s + 64'd16384) >> 15;
      rom[j] = (r > 64'd32768) ? 16'd32768 : r[15:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/eight_channel_sine_lfo_modulator.sv
// Top level: stream ports, configuration registers, shared frame-rate product and lanes
`timescale 1ns / 1ps
`default_nettype none

// Eight-channel sine LFO modulator. Each request carries a frame number and eight
// Q0.16 base levels and produces one request of eight modulated levels. The block
// is fully pipelined: it takes one request per clock while the pipeline is not held
// full by back-pressure. The depth is set by the per-lane phase computation, two
// reciprocal-multiply constant divisions, each followed by a remainder correction,
// then the registered sine table read and the two-step depth scaling. Eight
// identical lanes run side by side and share one frame-times-rate multiplier.
// Back-pressure stalls only the full part of the pipeline: s_tready_o drops only
// when every stage holds a result and the output is not being taken.
// Configuration (index 0 auto_enable, 1 mod_depth, 2 lfo_rate) must be written
// while no request is in flight; writes to index 3 are ignored.
module eight_channel_sine_lfo_modulator
  import ecslm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // frame_number, base_master, base_chance, base_geometry, base_texture,
  // base_missing, base_color, base_depth_delay, base_chaos, one zero bit
  input  wire logic                 s_tvalid_i,
  output logic                      s_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_tdata_i,
  // mod_master, mod_chance, mod_geometry, mod_texture, mod_missing,
  // mod_color, mod_depth_delay, mod_chaos
  output logic                      m_tvalid_o,
  input  wire logic                 m_tready_i,
  output logic      [M_TDATA_W-1:0] m_tdata_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_AW-1:0]    cfg_addr_i,
  input  wire logic [CFG_DW-1:0]    cfg_wdata_i
);

  // configuration registers
  logic        auto_enable_q;
  logic [15:0] mod_depth_q;
  logic [15:0] lfo_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_enable_q <= 1'b0;
      mod_depth_q   <= 16'd0;
      lfo_rate_q    <= LFO_RATE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_AUTO_ENABLE: auto_enable_q <= cfg_wdata_i[0];
        REG_MOD_DEPTH:   mod_depth_q   <= cfg_wdata_i;
        REG_LFO_RATE:    lfo_rate_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // depth sign and magnitude
  mod_ctrl_t mod_ctrl;

  assign mod_ctrl.enable = auto_enable_q;
  assign mod_ctrl.neg    = mod_depth_q[15];
  assign mod_ctrl.dmag   = mod_depth_q[15] ? 16'(17'h10000 - {1'b0, mod_depth_q})
                                           : mod_depth_q;

  // stage valids; a stage moves when the output is taken or it or any later stage is free
  logic [STAGES-1:0] valid_d, valid_q;
  logic [STAGES-1:0] stage_en;

  for (genvar i = 0; i < int'(STAGES); i++) begin : g_en
    assign stage_en[i] = m_tready_i || !(&valid_q[STAGES-1:i]);
  end

  always_comb begin
    valid_d[0] = stage_en[0] ? s_tvalid_i : valid_q[0];
    for (int i = 1; i < int'(STAGES); i++) begin
      valid_d[i] = stage_en[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_tready_o = stage_en[0];
  assign m_tvalid_o = valid_q[STAGES-1];

  // input register
  logic [FRAME_BITS-1:0] frame_q;
  logic [LEVEL_W-1:0]    base0_q [CHANNELS];

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      frame_q <= FRAME_BITS'(s_tdata_i[FRAME_FIELD_W-1:0]);
      for (int c = 0; c < int'(CHANNELS); c++) begin
        base0_q[c] <= s_tdata_i[FRAME_FIELD_W + c*LEVEL_W +: LEVEL_W];
      end
    end
  end

  // frame times rate, shared by all lanes
  logic [PROD_W-1:0]  prod_q;
  logic [LEVEL_W-1:0] base1_q [CHANNELS];

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      prod_q  <= PROD_W'(frame_q) * PROD_W'(lfo_rate_q);
      base1_q <= base0_q;
    end
  end

  // lanes and merge of their output registers
  logic [LEVEL_W-1:0] level [CHANNELS];

  for (genvar g = 0; g < int'(CHANNELS); g++) begin : g_lane
    lane_const_t lane_const;

    assign lane_const.div     = 9'(LANE_DIV[g]);
    assign lane_const.recip_a = QA_W'(RECIP_A[g]);
    assign lane_const.recip_b = RB_W'(RECIP_B[g]);
    assign lane_const.offset  = 16'(LANE_OFFSET[g]);
    assign lane_const.half    = 1'(LANE_HALF[g]);

    ecslm_lane u_lane (
      .clk_i        (clk_i),
      .stage_en_i   (stage_en[STAGES-1:LANE_FIRST]),
      .lane_const_i (lane_const),
      .mod_ctrl_i   (mod_ctrl),
      .prod_i       (prod_q),
      .base_i       (base1_q[g]),
      .level_o      (level[g])
    );

    assign m_tdata_o[g*LEVEL_W +: LEVEL_W] = level[g];
  end

endmodule

`default_nettype wire

FILE: rtl/ecslm_lane.sv
// One modulation lane: phase by constant division, sine lookup, scaling and saturation
`timescale 1ns / 1ps
`default_nettype none

module ecslm_lane
  import ecslm_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic [LANE_STAGES-1:0] stage_en_i,
  input  wire lane_const_t            lane_const_i,
  input  wire mod_ctrl_t              mod_ctrl_i,
  input  wire logic [PROD_W-1:0]      prod_i,
  input  wire logic [LEVEL_W-1:0]     base_i,
  output logic      [LEVEL_W-1:0]     level_o
);

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // base level travels alongside the lane data
  logic [LEVEL_W-1:0] base_q [LANE_STAGES-1];

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      base_q[0] <= base_i;
    end
    for (int k = 1; k < int'(LANE_STAGES) - 1; k++) begin
      if (stage_en_i[k]) begin
        base_q[k] <= base_q[k-1];
      end
    end
  end

  // quotient estimate of the upper product bits, at most one short
  logic [X_W-1:0]      x;
  logic [X_W+QA_W-1:0] xa_full;
  logic [QA_W-1:0]     qa_q;
  logic [9:0]          xlo_q;
  logic [13:0]         nlo_q;

  assign x       = prod_i[PROD_W-1:14];
  assign xa_full = (X_W+QA_W)'(x) * (X_W+QA_W)'(lane_const_i.recip_a);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      qa_q  <= xa_full[X_W +: QA_W];
      xlo_q <= x[9:0];
      nlo_q <= prod_i[13:0];
    end
  end

  // remainder below twice the divisor, exact in ten bits
  logic [QA_W+8:0] qa_c;
  logic [9:0]      r0_d, r0_q;
  logic [13:0]     nlo3_q;

  assign qa_c = (QA_W+9)'(qa_q) * (QA_W+9)'(lane_const_i.div);
  assign r0_d = xlo_q - qa_c[9:0];

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      r0_q   <= r0_d;
      nlo3_q <= nlo_q;
    end
  end

  // correct the remainder and rebuild the reduced dividend times four
  logic [9:0]     rh;
  logic [Y_W-1:0] y_d, y_q;

  assign rh  = (r0_q >= {1'b0, lane_const_i.div}) ? r0_q - {1'b0, lane_const_i.div} : r0_q;
  assign y_d = {rh[8:0], nlo3_q, 2'b00};

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      y_q <= y_d;
    end
  end

  // second quotient estimate gives the upper phase bits
  logic [Y_W+RB_W-1:0] yb_full;
  logic [15:0]         q2e_q;
  logic [9:0]          ylo_q;

  assign yb_full = (Y_W+RB_W)'(y_q) * (Y_W+RB_W)'(lane_const_i.recip_b);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      q2e_q <= yb_full[Y_W +: 16];
      ylo_q <= y_q[9:0];
    end
  end

  // remainder of the second estimate
  logic [24:0] q2_c;
  logic [9:0]  r2_q;
  logic [15:0] q2e6_q;

  assign q2_c = 25'(q2e_q) * 25'(lane_const_i.div);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[4]) begin
      r2_q   <= ylo_q - q2_c[9:0];
      q2e6_q <= q2e_q;
    end
  end

  // phase plus channel offset, quadrant folding into a table address
  logic [15:0]                hi;
  logic [15:0]                ph;
  logic [SINE_TABLE_BITS+1:0] idx;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-1:0] qi;
  logic [ROM_AW-1:0]          addr_d, addr_q;
  logic                       lower7_q;

  assign hi     = q2e6_q + 16'(r2_q >= {1'b0, lane_const_i.div});
  assign ph     = hi + lane_const_i.offset;
  assign idx    = ph[15 -: SINE_TABLE_BITS+2];
  assign quad   = idx[SINE_TABLE_BITS+1:SINE_TABLE_BITS];
  assign qi     = idx[SINE_TABLE_BITS-1:0];
  assign addr_d = quad[0] ? ROM_AW'(SINE_N) - {1'b0, qi} : {1'b0, qi};

  always_ff @(posedge clk_i) begin
    if (stage_en_i[5]) begin
      addr_q   <= addr_d;
      lower7_q <= quad[1];
    end
  end

  // quarter-wave table read
  logic [15:0] sine_q;
  logic        lower8_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[6]) begin
      sine_q   <= SINE_ROM[addr_q];
      lower8_q <= lower7_q;
    end
  end

  // lfo level times depth magnitude
  logic [16:0] lfo;
  logic [32:0] dl_full;
  logic [31:0] dl_q;

  assign lfo     = lower8_q ? 17'd32768 - {1'b0, sine_q} : 17'd32768 + {1'b0, sine_q};
  assign dl_full = 33'(mod_ctrl_i.dmag) * 33'(lfo);

  always_ff @(posedge clk_i) begin
    if (stage_en_i[7]) begin
      dl_q <= dl_full[31:0];
    end
  end

  // times 65535 by shift and subtract, rounded shift down
  logic [47:0] big;
  logic [47:0] rnd;
  logic [17:0] mag_q;

  assign rnd = lane_const_i.half ? (48'd1 << 30) : (48'd1 << 29);
  assign big = {dl_q, 16'd0} - 48'(dl_q) + rnd;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[8]) begin
      mag_q <= lane_const_i.half ? {1'b0, big[47:31]} : big[47:30];
    end
  end

  // apply sign, saturate, or pass the base level when disabled
  logic [19:0]        sum;
  logic [LEVEL_W-1:0] sat;

  assign sum = mod_ctrl_i.neg ? {4'd0, base_q[8]} - {2'd0, mag_q}
                              : {4'd0, base_q[8]} + {2'd0, mag_q};

  always_comb begin
    if (sum[19]) begin
      sat = '0;
    end else if (sum[18:16] != 3'd0) begin
      sat = '1;
    end else begin
      sat = sum[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[9]) begin
      level_o <= mod_ctrl_i.enable ? sat : base_q[8];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ecslm_checker.sv
// Port-level checker for the sine LFO modulator and its bind
`timescale 1ns / 1ps
`default_nettype none

module ecslm_checker
  import ecslm_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 s_tvalid_i,
  input wire logic                 s_tready_o,
  input wire logic [S_TDATA_W-1:0] s_tdata_i,
  input wire logic                 m_tvalid_o,
  input wire logic                 m_tready_i,
  input wire logic [M_TDATA_W-1:0] m_tdata_o,
  input wire logic                 cfg_we_i,
  input wire logic [CFG_AW-1:0]    cfg_addr_i,
  input wire logic [CFG_DW-1:0]    cfg_wdata_i
);

  // copy of the enable register as seen on the configuration port
  logic enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_we_i && cfg_addr_i == REG_AUTO_ENABLE) begin
      enable_q <= cfg_wdata_i[0];
    end
  end

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result changed while stalled");

  // input is refused only when the output holds a result that is not taken
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o && !m_tready_i)
    else $error("input refused with room in the pipeline");

  // a result after an empty output cycle ran through without stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) |-> $past(s_tvalid_i && s_tready_o, STAGES))
    else $error("result without matching request");

  // disabled modulation passes base levels through
  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid_o) && !$past(enable_q) |->
      m_tdata_o == $past(s_tdata_i[FRAME_FIELD_W + M_TDATA_W - 1:FRAME_FIELD_W], STAGES))
    else $error("bypass result differs from base levels");

endmodule

bind eight_channel_sine_lfo_modulator ecslm_checker u_ecslm_checker (.*);

`default_nettype wire
